// ===== src/tksel_pkg.sv =====
`default_nettype none
package tksel_pkg;

  // fixed field widths
  localparam int SCORE_W = 32;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 4;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 48;

  // parameter defaults
  localparam int TOPK_MAX_DEF    = 8;
  localparam int MAX_CLASSES_DEF = 1024;

  localparam logic [CFG_W-1:0] KEEP_RESET = 4'd5;

  // one chain entry
  typedef struct packed {
    logic               vld;
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   pos;
  } tksel_entry_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic ins;    // offer the new element to the chain
    logic drain;  // move every entry one cell toward the head
    logic clear;  // drop all entries
  } tksel_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } tksel_state_t;

endpackage
`default_nettype wire

// ===== src/tksel_cell.sv =====
`default_nettype none
module tksel_cell (
  input  wire                           clk,
  input  wire                           rst,
  input  tksel_pkg::tksel_ctrl_t        ctrl,
  input  wire [tksel_pkg::SCORE_W-1:0]  new_score,
  input  wire [tksel_pkg::POS_W-1:0]    new_pos,
  input  tksel_pkg::tksel_entry_t       prv,
  input  wire                           prv_gt,
  input  tksel_pkg::tksel_entry_t       nxt,
  output tksel_pkg::tksel_entry_t       ent,
  output logic                          gt
);
  import tksel_pkg::*;

  logic               vld;
  logic [SCORE_W-1:0] score;
  logic [POS_W-1:0]   pos;
  logic               shift_in;
  logic               take_new;

  // new element beats this entry; an empty cell is always beaten,
  // equal scores leave the older (lower position) entry in front
  assign gt = !vld || ($signed(new_score) > $signed(score));

  assign shift_in = ctrl.ins && prv_gt;
  assign take_new = ctrl.ins && gt && !prv_gt;

  assign ent = '{vld: vld, score: score, pos: pos};

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.clear) begin
      vld <= 1'b0;
    end else if (ctrl.drain) begin
      vld <= nxt.vld;
    end else if (shift_in) begin
      vld <= prv.vld;
    end else if (take_new) begin
      vld <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      score <= nxt.score;
      pos   <= nxt.pos;
    end else if (shift_in) begin
      score <= prv.score;
      pos   <= prv.pos;
    end else if (take_new) begin
      score <= new_score;
      pos   <= new_pos;
    end
  end

endmodule
`default_nettype wire

// ===== src/top_k_select_with_index.sv =====
`default_nettype none
// Channel   Dir  Fields (tdata low bit up)                 tlast
// s_axis    in   score[31:0]                               end_of_vector
// m_axis    out  ranked_score[31:0], class_position[41:32] final_rank
// cfg       in   keep_count[3:0]                           -
//
// One score is taken per cycle while a vector streams in; each cell of
// the insertion chain compares the new score in the same cycle.
// After the marked element, min(kept, k) ranks leave at one per cycle while m_axis_tready
// is high, the chain draining toward the head; input is held off meanwhile.
// Reset clears the chain, counters and sets keep_count to 5.
// Output stalls hold the head entry; no data is lost.
module top_k_select_with_index #(
  parameter int TOPK_MAX    = tksel_pkg::TOPK_MAX_DEF,
  parameter int MAX_CLASSES = tksel_pkg::MAX_CLASSES_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [tksel_pkg::IN_W-1:0]    s_axis_tdata,  // score[31:0]
  input  wire                          s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [tksel_pkg::OUT_W-1:0]  m_axis_tdata,  // ranked_score, class_position
  output logic                         m_axis_tlast,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [tksel_pkg::CFG_W-1:0]   cfg_data
);
  import tksel_pkg::*;

  localparam int CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int KW    = $clog2(TOPK_MAX + 1);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_CLASSES);
  localparam logic [KW-1:0]    KEPT_MAX = KW'(TOPK_MAX);

  tksel_state_t     state, state_next;
  logic [CFG_W-1:0] keep_count;
  logic [CNT_W-1:0] element_counter, element_counter_next;
  logic [KW-1:0]    kept_valid, kept_valid_next;
  logic [KW-1:0]    remaining, remaining_next;
  logic [KW-1:0]    k_eff;
  logic [KW-1:0]    kept_after;
  logic [7:0]       k8;
  logic             in_xfer, out_xfer, in_range;
  tksel_ctrl_t      ctrl;

  tksel_entry_t     ent    [TOPK_MAX];
  tksel_entry_t     prv_e  [TOPK_MAX];
  tksel_entry_t     nxt_e  [TOPK_MAX];
  logic             gt     [TOPK_MAX];
  logic             prv_gt [TOPK_MAX];

  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (cfg_valid) begin
      keep_count <= cfg_data;
    end
  end

  // effective k: zero reads as one, clipped at the chain length
  always_comb begin
    k8 = 8'(keep_count);
    if (k8 == 8'd0) begin
      k8 = 8'd1;
    end
    if (k8 > 8'(TOPK_MAX)) begin
      k8 = 8'(TOPK_MAX);
    end
    k_eff = KW'(k8);
  end

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign in_range = element_counter < CNT_LIM;

  // entry count once the current element is in
  assign kept_after = (in_range && kept_valid < KEPT_MAX) ? kept_valid + 1'b1 : kept_valid;

  // sequencer
  always_comb begin
    state_next           = state;
    element_counter_next = element_counter;
    kept_valid_next      = kept_valid;
    remaining_next       = remaining;
    ctrl                 = '0;
    s_axis_tready        = 1'b0;
    m_axis_tvalid        = 1'b0;
    case (state)
      ST_FILL: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          ctrl.ins        = in_range;
          kept_valid_next = kept_after;
          if (in_range) begin
            element_counter_next = element_counter + 1'b1;
          end
          if (s_axis_tlast) begin
            remaining_next = (kept_after < k_eff) ? kept_after : k_eff;
            state_next     = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (out_xfer) begin
          ctrl.drain     = 1'b1;
          remaining_next = remaining - 1'b1;
          if (remaining == KW'(1)) begin
            ctrl.clear           = 1'b1;
            element_counter_next = '0;
            kept_valid_next      = '0;
            state_next           = ST_FILL;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_FILL;
      element_counter <= '0;
      kept_valid      <= '0;
      remaining       <= '0;
    end else begin
      state           <= state_next;
      element_counter <= element_counter_next;
      kept_valid      <= kept_valid_next;
      remaining       <= remaining_next;
    end
  end

  // head of the chain drives the output
  assign m_axis_tdata = {{(OUT_W - SCORE_W - POS_W){1'b0}}, ent[0].pos, ent[0].score};
  assign m_axis_tlast = (remaining == KW'(1));

  // insertion chain
  for (genvar i = 0; i < TOPK_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prv_e[i]  = '0;
      assign prv_gt[i] = 1'b0;
    end else begin : g_mid
      assign prv_e[i]  = ent[i-1];
      assign prv_gt[i] = gt[i-1];
    end
    if (i == TOPK_MAX - 1) begin : g_tail
      assign nxt_e[i] = '0;
    end else begin : g_body
      assign nxt_e[i] = ent[i+1];
    end

    tksel_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_score (s_axis_tdata[SCORE_W-1:0]),
      .new_pos   (POS_W'(element_counter)),
      .prv       (prv_e[i]),
      .prv_gt    (prv_gt[i]),
      .nxt       (nxt_e[i]),
      .ent       (ent[i]),
      .gt        (gt[i])
    );
  end

endmodule
`default_nettype wire

// ===== src/tksel_checker.sv =====
`default_nettype none
module tksel_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire                          s_axis_tlast,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [tksel_pkg::OUT_W-1:0]   m_axis_tdata,
  input wire                          m_axis_tlast
);
  import tksel_pkg::*;

  // input is never taken while ranks are being reported
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // the marked element starts the report at once
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
    else $error("no report after end of vector");

  // a non-final rank is followed by another rank
  a_more: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("report ended before final rank");

  // after the final rank the block is ready for a new vector
  a_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid))
    else $error("not back to input after final rank");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind top_k_select_with_index tksel_checker u_tksel_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
